// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Result fields, status codes and the command that is broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W = 8;
  localparam int POP_W   = 8;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } spq_cmd_t;

  typedef struct packed {
    logic [POP_W-1:0] popped;
    spq_status_t      status;
    logic [OCC_W-1:0] occ;
  } spq_res_t;

endpackage

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one stored value. On an insert it shifts toward the tail when its value
// is greater than the new one, or takes the new value at the insertion point.
// On a pop it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  spq_cmd_t              cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] ins_value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_take,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  take
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  occupied;

  assign occupied = count > CNT_W'(IDX);
  assign take     = (occupied && (data_r > ins_value)) || (count == CNT_W'(IDX));
  assign data     = data_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && take) begin
      data_nxt = left_take ? left_data : ins_value;
    end else if (cmd.pop) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Min-first queue kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// The queue takes one beat per clock cycle, insert or pop alike, while in_stall is
// low. Each result beat is registered in the output register, or in the second
// buffer entry while the output is held. Every cell compares its value with the
// incoming one in parallel and moves in the same cycle. A two-entry output buffer
// lets a beat be accepted while a result still waits; in_stall rises only when
// both entries hold results. A pop on an empty queue returns zero with the
// empty status; an insert into a full queue is dropped with the full status.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POP_W-1:0]   out_popped_value,
  output logic [STAT_W-1:0]  out_status,
  output logic [OCC_W-1:0]   out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  spq_res_t              out_r;
  spq_res_t              skid_r;
  spq_res_t              res;
  spq_cmd_t              cmd;
  logic                  in_fire;
  logic                  out_fire;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] ins_val;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_take [DEPTH];

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign ins_val  = DATA_WIDTH'(in_value);

  assign cmd.ins = in_fire && (in_action == ACT_INSERT) && !full;
  assign cmd.pop = in_fire && (in_action == ACT_POP) && !empty;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    res.popped = '0;
    res.status = ST_DONE;
    res.occ    = OCC_W'(count_nxt);
    if (in_action == ACT_POP) begin
      if (empty) begin
        res.status = ST_EMPTY;
      end else begin
        res.popped = POP_W'(cell_data[0]);
      end
    end else if (full) begin
      res.status = ST_FULL;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_take;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = ins_val;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    spq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .ins_value  (ins_val),
      .left_data  (left_data),
      .left_take  (left_take),
      .right_data (right_data),
      .data       (cell_data[i]),
      .take       (cell_take[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        if (out_valid_r && !out_fire) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (out_fire && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_r.popped;
  assign out_status       = out_r.status;
  assign out_occupancy    = out_r.occ;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stored count exceeds depth");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("buffer entry held while output register is empty");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_occupancy == '0 && out_popped_value == '0))
    else $error("empty status with nonzero occupancy or value");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_occupancy == OCC_W'(DEPTH)))
    else $error("full status without full occupancy");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> (count_r == $past(count_r)))
    else $error("stored count changed without an accepted beat");
`endif

endmodule

// File: bench/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches both channels of the queue, keeps its own ascending copy of the
// stored values, works out the result of every accepted input beat and
// compares each accepted result beat, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [POP_W-1:0]   out_popped_value,
  input  logic [STAT_W-1:0]  out_status,
  input  logic [OCC_W-1:0]   out_occupancy,
  output int                 mismatches,
  output int                 outstanding
);

  logic [VALUE_W-1:0] held_values[$];
  spq_res_t           due_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic spq_res_t apply_queue_op(logic act, logic [VALUE_W-1:0] val);
    spq_res_t res;
    int       pos;
    res.popped = '0;
    res.status = ST_DONE;
    if (act == ACT_INSERT) begin
      if (held_values.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_values.size() && held_values[pos] <= val) pos++;
        held_values.insert(pos, val);
      end
    end else if (held_values.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped = held_values.pop_front();
    end
    res.occ = OCC_W'(held_values.size());
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    spq_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) due_results.push_back(apply_queue_op(in_action, in_value));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with no result due");
        end else begin
          want = due_results.pop_front();
          if (out_popped_value !== want.popped)
            report_mismatch($sformatf("popped_value got %0d expected %0d",
                                      out_popped_value, want.popped));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_status, want.status));
          if (out_occupancy !== want.occ)
            report_mismatch($sformatf("occupancy got %0d expected %0d",
                                      out_occupancy, want.occ));
        end
      end
    end
    outstanding <= due_results.size();
  end

endmodule

// File: bench/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives directed and random insert and pop beats into the queue under several
// idle and stall patterns, including a long output hold that backs the queue
// up, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = ACT_INSERT;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [POP_W-1:0]   out_popped_value;
  logic [STAT_W-1:0]  out_status;
  logic [OCC_W-1:0]   out_occupancy;

  int mismatches;
  int outstanding;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;

  sorted_priority_queue u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  sorted_priority_queue_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_beat(logic act, logic [VALUE_W-1:0] val, int idle_pct);
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic run_random_ops(int count, int idle_pct);
    int               pop_pct;
    logic             act;
    logic [VALUE_W-1:0] val;
    pop_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       pop_pct = 15;
          1:       pop_pct = 50;
          default: pop_pct = 85;
        endcase
      end
      act = ($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_INSERT;
      val = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 7))
                                        : VALUE_W'($urandom_range(0, 255));
      send_beat(act, val, idle_pct);
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] fill_values[16];
    fill_values = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'h01, 8'hFE,
                    8'h80, 8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h80, 8'h10, 8'hEF};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pop, fill to the brim with extremes and ties, overflow, then drain some.
    send_beat(ACT_POP, 8'h5A, 0);
    foreach (fill_values[i]) send_beat(ACT_INSERT, fill_values[i], 0);
    send_beat(ACT_INSERT, 8'h00, 0);
    send_beat(ACT_INSERT, 8'hFF, 0);
    repeat (5) send_beat(ACT_POP, 8'hFF, 0);

    run_random_ops(170, 0);
    stall_pct <= 0;
    run_random_ops(170, 47);
    stall_pct <= 47;
    run_random_ops(170, 0);
    stall_pct <= 30;
    run_random_ops(170, 30);

    // The receiver holds off while the sender keeps offering beats back to back.
    stall_pct     <= 0;
    hold_requests <= hold_requests + 1;
    run_random_ops(40, 0);

    in_valid  <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
